@@ rtl/bcg_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helper functions for the byte/chunk gearbox
// no dependencies; imported by every module of the block

package bcg_pkg;

   // byte width and working accumulator width (held bits plus one byte)
   localparam int BYTE_BITS = 8;
   localparam int ACC_W     = 2 * BYTE_BITS - 1;
   localparam int CNT_W     = 4;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION  = 2'd1;

   // reset values of the registers
   localparam logic [CNT_W-1:0] CHUNK_BITS_RESET = 4'd2;
   localparam logic             DIR_UNPACK       = 1'b0;
   localparam logic             DIR_PACK         = 1'b1;

   // input item kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // default depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] value_res;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_UNPACK,
      OP_PACK,
      OP_FLUSH
   } op_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] k;
      logic [7:0]       value;
   } cmd_type;

   // chunk size as used: zero acts as one, above a byte acts as a byte
   function automatic logic [CNT_W-1:0] eff_chunk(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] k;
      if (raw == '0) begin
         k = CNT_W'(1);
      end else if (raw > CNT_W'(BYTE_BITS)) begin
         k = CNT_W'(BYTE_BITS);
      end else begin
         k = raw;
      end
      return k;
   endfunction

   // mask of the low k bits of a byte, k from 1 to 8
   function automatic logic [BYTE_BITS-1:0] chunk_mask(input logic [CNT_W-1:0] k);
      logic [BYTE_BITS:0] ones;
      ones = (BYTE_BITS+1)'(1) << k;
      return BYTE_BITS'(ones - (BYTE_BITS+1)'(1));
   endfunction

endpackage

@@ rtl/bcg_front.sv @@
`timescale 1ns / 1ps
// front end: configuration registers, input handshake and item classification
// depends on bcg_pkg

module bcg_front
   import bcg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   queue_full,
   output logic                   push,
   output cmd_type                push_data,
   output logic                   cfg_clear
);

   logic [CNT_W-1:0] chunk_bits_ff, chunk_bits_in;
   logic             direction_ff, direction_in;
   logic [CNT_W-1:0] k;

   // register writes
   always_comb begin
      chunk_bits_in = chunk_bits_ff;
      direction_in  = direction_ff;
      cfg_clear     = 1'b0;
      if (csr_we) begin
         if (csr_index == CSR_CHUNK_BITS) begin
            chunk_bits_in = csr_wdata[CNT_W-1:0];
            cfg_clear     = 1'b1;
         end else if (csr_index == CSR_DIRECTION) begin
            direction_in = csr_wdata[0];
            cfg_clear    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bits_ff <= CHUNK_BITS_RESET;
         direction_ff  <= DIR_UNPACK;
      end else begin
         chunk_bits_ff <= chunk_bits_in;
         direction_ff  <= direction_in;
      end
   end

   // accept while the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign k         = eff_chunk(chunk_bits_ff);

   // classify the item into a command for the back end
   always_comb begin
      push_data.k     = k;
      push_data.value = req_data.value;
      if (req_data.kind == KIND_FLUSH) begin
         push_data.op = OP_FLUSH;
      end else if (direction_ff == DIR_PACK) begin
         push_data.op    = OP_PACK;
         push_data.value = req_data.value & chunk_mask(k);
      end else begin
         push_data.op = OP_UNPACK;
      end
   end

endmodule

@@ rtl/bcg_queue.sv @@
`timescale 1ns / 1ps
// small command queue between front and back end
// depends on bcg_pkg for the command type

module bcg_queue
   import bcg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data,
   output logic    full
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update with wrap at the last entry
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("queue count did not grow on push");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

endmodule

@@ rtl/bcg_back.sv @@
`timescale 1ns / 1ps
// back end: holds leftover bits, emits chunks or bytes through an output register
// depends on bcg_pkg

module bcg_back
   import bcg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cfg_clear,
   input  logic    head_valid,
   input  cmd_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              active_ff, active_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              load;
   logic [ACC_W-1:0]  merged;
   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  remain;
   logic [CNT_W-1:0]  cur_k;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_k    = active_ff ? k_ff : head_data.k;
   assign merged   = acc_ff | (ACC_W'(head_data.value) << cnt_ff);

   // up to one result per free cycle: continue unpacking, else take a command
   always_comb begin
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      active_in   = active_ff;
      pop         = 1'b0;
      load        = 1'b0;
      total       = '0;
      remain      = '0;
      rsp_data_in = rsp_data_ff;
      priority if (cfg_clear) begin
         acc_in    = '0;
         cnt_in    = '0;
         active_in = 1'b0;
      end else if (out_free && active_ff) begin
         remain                = cnt_ff - cur_k;
         load                  = 1'b1;
         rsp_data_in.value_res = acc_ff[BYTE_BITS-1:0] & chunk_mask(cur_k);
         rsp_data_in.last      = (remain < cur_k);
         acc_in                = acc_ff >> cur_k;
         cnt_in                = remain;
         active_in             = !(remain < cur_k);
      end else if (out_free && head_valid) begin
         pop = 1'b1;
         unique case (head_data.op)
            OP_UNPACK: begin
               // first chunk is loaded in the same cycle the byte is taken
               total                 = cnt_ff + CNT_W'(BYTE_BITS);
               remain                = total - cur_k;
               load                  = 1'b1;
               rsp_data_in.value_res = merged[BYTE_BITS-1:0] & chunk_mask(cur_k);
               rsp_data_in.last      = (remain < cur_k);
               acc_in                = merged >> cur_k;
               cnt_in                = remain;
               k_in                  = cur_k;
               active_in             = !(remain < cur_k);
            end
            OP_PACK: begin
               total = cnt_ff + cur_k;
               if (total >= CNT_W'(BYTE_BITS)) begin
                  load                  = 1'b1;
                  rsp_data_in.value_res = merged[BYTE_BITS-1:0];
                  rsp_data_in.last      = 1'b1;
                  acc_in                = merged >> BYTE_BITS;
                  cnt_in                = total - CNT_W'(BYTE_BITS);
               end else begin
                  acc_in = merged;
                  cnt_in = total;
               end
            end
            OP_FLUSH: begin
               if (cnt_ff != '0) begin
                  load                  = 1'b1;
                  rsp_data_in.value_res = acc_ff[BYTE_BITS-1:0];
                  rsp_data_in.last      = 1'b1;
               end
               acc_in = '0;
               cnt_in = '0;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end else begin
         // stalled or nothing to do: hold
         acc_in = acc_ff;
      end
   end

   // output register valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_active_has_chunk: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff >= k_ff))
      else $error("unpacking active without a whole chunk left");

   a_idle_below_byte: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (cnt_ff < CNT_W'(BYTE_BITS)))
      else $error("held count reached a full byte while idle");

   a_held_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> ((acc_ff >> cnt_ff) == '0))
      else $error("bits above the held count are not zero");

   a_unpack_emits: assert property (@(posedge clock) disable iff (reset)
      (pop && !cfg_clear && head_data.op == OP_UNPACK) |=> rsp_valid_ff)
      else $error("unpacked byte gave no first chunk");

endmodule

@@ rtl/byte_chunk_gearbox.sv @@
`timescale 1ns / 1ps
// byte_chunk_gearbox: lsb-first converter between bytes and 1 to 8 bit chunks
// path: an accepted item enters the queue, then its results are registered at the output
// throughput: while the output register is free, unpack gives one chunk per cycle,
//    floor((held + 8) / chunk_bits), at most 8, and pack and flush items go one per cycle
// reset: synchronous, chunk_bits 2, unpack direction, no held bits, queue empty
// depends on bcg_pkg, bcg_front, bcg_queue, bcg_back

module byte_chunk_gearbox
   import bcg_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    queue_full;
   logic    push;
   cmd_type push_data;
   logic    cfg_clear;
   logic    pop;
   logic    head_valid;
   cmd_type head_data;

   // front: registers and classification
   bcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data),
      .cfg_clear  (cfg_clear)
   );

   // command queue
   bcg_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   // back: bit accumulator and result register
   bcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_clear  (cfg_clear),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/tb_byte_chunk_gearbox.sv @@
`timescale 1ns / 1ps
// self-checking bench for byte_chunk_gearbox: directed and random streams in both directions
// depends on bcg_pkg and the byte_chunk_gearbox rtl; a built-in converter predicts every item

module tb_byte_chunk_gearbox;
   import bcg_pkg::*;

   // spare register indexes, writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   // cycles to let result-free items leave the pipeline before a register write
   localparam int SETTLE_CYCLES = 16;
   // cycles without any handshake before the run is abandoned
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 200;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PULSED
   } ready_pattern_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // converter state mirrored from the block
   logic [3:0]     chunk_cfg  = CHUNK_BITS_RESET;
   logic           dir_cfg    = DIR_UNPACK;
   logic [7:0]     held_bits  = '0;
   logic [3:0]     held_count = '0;
   rsp_type        converted_q[$];

   int                error_count     = 0;
   int                items_sent      = 0;
   int                results_checked = 0;
   int                settings_used   = 0;
   int                burst_left      = 1;
   bit                sending         = 1'b0;
   int                idle_cycles     = 0;
   ready_pattern_type ready_pattern   = READY_ALWAYS;
   int                pattern_left    = 0;

   byte_chunk_gearbox dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // low n bits set, n from 0 to 8
   function automatic logic [7:0] low_bits(input logic [3:0] n);
      return 8'hFF >> (4'd8 - n);
   endfunction

   // work out the chunks or bytes that one accepted item produces
   task automatic convert_item(input req_type item);
      logic [15:0] acc;
      logic [4:0]  avail;
      logic [3:0]  k;
      int          n;
      rsp_type     r;
      k = (chunk_cfg == 4'd0) ? 4'd1 : (chunk_cfg > 4'd8) ? 4'd8 : chunk_cfg;
      if (item.kind == KIND_FLUSH) begin
         if (held_count != 4'd0) begin
            r.value_res = held_bits;
            r.last      = 1'b1;
            converted_q.push_back(r);
         end
         held_bits  = '0;
         held_count = '0;
      end else if (dir_cfg == DIR_UNPACK) begin
         acc   = 16'(held_bits) | (16'(item.value) << held_count);
         avail = 5'(held_count) + 5'd8;
         n     = 0;
         while (avail >= 5'(k) && n < 8) begin
            r.value_res = acc[7:0] & low_bits(k);
            avail       = avail - 5'(k);
            n++;
            r.last      = (avail < 5'(k)) || (n == 8);
            converted_q.push_back(r);
            acc         = acc >> k;
         end
         held_count = avail[3:0];
         held_bits  = acc[7:0] & low_bits(avail[3:0]);
      end else begin
         acc   = 16'(held_bits) | (16'(item.value & low_bits(k)) << held_count);
         avail = 5'(held_count) + 5'(k);
         if (avail >= 5'd8) begin
            r.value_res = acc[7:0];
            r.last      = 1'b1;
            converted_q.push_back(r);
            acc   = acc >> 8;
            avail = avail - 5'd8;
         end
         held_count = avail[3:0];
         held_bits  = acc[7:0] & low_bits(avail[3:0]);
      end
   endtask

   // offer one item, hold it until taken, then maybe pause between bursts
   task automatic send_item(input logic kind, input logic [7:0] value);
      req_type item;
      int      gap;
      item.kind  = kind;
      item.value = value;
      req_valid <= 1'b1;
      req_data  <= item;
      sending    = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      convert_item(item);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            sending    = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering, wait for every predicted result, then let the pipeline empty
   task automatic drain();
      if (sending) begin
         req_valid <= 1'b0;
         sending    = 1'b0;
      end
      while (converted_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller lowers the write enable afterwards
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CHUNK_BITS: begin
            chunk_cfg  = data;
            held_bits  = '0;
            held_count = '0;
         end
         CSR_DIRECTION: begin
            dir_cfg    = data[0];
            held_bits  = '0;
            held_count = '0;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [3:0] chunk, input logic [3:0] dir_word);
      csr_write(CSR_CHUNK_BITS, chunk);
      csr_write(CSR_DIRECTION, dir_word);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (converted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %02h last %0b",
                                      rsp_data.value_res, rsp_data.last));
         end else begin
            want = converted_q.pop_front();
            if (rsp_data.value_res !== want.value_res)
               report_mismatch($sformatf("value_res %02h, want %02h",
                                         rsp_data.value_res, want.value_res));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b (value %02h)",
                                         rsp_data.last, want.last, want.value_res));
            results_checked++;
         end
      end
   end

   // receiver stalls, switching pattern every so often
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern = ready_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(20, 120);
      end
      pattern_left--;
      case (ready_pattern)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 7);
         READY_SELDOM: rsp_ready <= ($urandom_range(0, 9) < 3);
         default:      rsp_ready <= ((pattern_left % 8) < 2);
      endcase
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset settings: two-bit chunks, unpack; a flush with nothing held gives nothing
   task automatic test_reset_state();
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_FLUSH, 8'hFF);
   endtask

   // unpack at the chunk size extremes, out-of-range sizes and straddling chunks
   task automatic test_unpack_sizes();
      drain();
      set_mode(4'd0, {3'b000, DIR_UNPACK});
      send_item(KIND_DATA, 8'hA5);
      drain();
      set_mode(4'd3, {3'b110, DIR_UNPACK});
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h81);
      send_item(KIND_FLUSH, 8'h00);
      drain();
      set_mode(4'd15, {3'b111, DIR_UNPACK});
      send_item(KIND_DATA, 8'h3C);
      drain();
      set_mode(4'd9, {3'b001, DIR_UNPACK});
      send_item(KIND_DATA, 8'hC6);
   endtask

   // pack full bytes, wide chunks, partial byte flush and an empty flush
   task automatic test_pack_sizes();
      drain();
      set_mode(4'd8, {3'b101, DIR_PACK});
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h00);
      drain();
      set_mode(4'd3, {3'b010, DIR_PACK});
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h05);
      send_item(KIND_DATA, 8'hFA);
      send_item(KIND_FLUSH, 8'h5A);
      send_item(KIND_FLUSH, 8'hA5);
      drain();
      set_mode(4'd0, {3'b011, DIR_PACK});
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_FLUSH, 8'h00);
   endtask

   // writes to unused indexes leave the held bits alone
   task automatic test_spare_index();
      drain();
      set_mode(4'd5, {3'b000, DIR_UNPACK});
      send_item(KIND_DATA, 8'hC3);
      drain();
      csr_write(CSR_SPARE_LO, 4'hF);
      csr_write(CSR_SPARE_HI, 4'hA);
      csr_we <= 1'b0;
      send_item(KIND_FLUSH, 8'h00);
   endtask

   // a register write, even of the same value, starts a fresh stream
   task automatic test_write_clears();
      drain();
      set_mode(4'd3, {3'b000, DIR_UNPACK});
      send_item(KIND_DATA, 8'h12);
      drain();
      csr_write(CSR_DIRECTION, {3'b100, DIR_UNPACK});
      csr_we <= 1'b0;
      send_item(KIND_FLUSH, 8'hFF);
   endtask

   // random streams, one setting per phase, extremes first
   task automatic test_random_streams();
      logic [3:0] chunk;
      logic [3:0] dir_word;
      int         phase;
      int         start_count;
      int         stream_len;
      phase       = 0;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         dir_word = 4'($urandom_range(0, 15));
         case (phase)
            0: begin chunk = 4'd1; dir_word[0] = DIR_UNPACK; end
            1: begin chunk = 4'd8; dir_word[0] = DIR_PACK;   end
            2: begin chunk = 4'd1; dir_word[0] = DIR_PACK;   end
            3: begin chunk = 4'd8; dir_word[0] = DIR_UNPACK; end
            default: begin
               chunk = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
            end
         endcase
         drain();
         set_mode(chunk, dir_word);
         stream_len = $urandom_range(12, 30);
         repeat (stream_len) begin
            if ($urandom_range(0, 11) == 0) send_item(KIND_FLUSH, 8'($urandom));
            else                            send_item(KIND_DATA, 8'($urandom));
         end
         // most streams end with a flush of the leftover
         if ($urandom_range(0, 3) != 0) send_item(KIND_FLUSH, 8'($urandom));
         phase++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_unpack_sizes();
      test_pack_sizes();
      test_spare_index();
      test_write_clears();
      test_random_streams();
      drain();
      if (converted_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", converted_q.size()));
      $display("covered %0d items under %0d register settings in both directions",
               items_sent, settings_used);
      $display("compared %0d results, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
